// File: rtl/core/bto_pkg.sv
// Shared types, request codes and edge arithmetic for the box overlap detector.
package bto_pkg;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_DETECT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Fixed widths of the result fields.
  localparam int OWNER_W      = 4;
  localparam int RESULT_LIMIT = 16;

  // Number of axes and width of a widened box edge.
  localparam int AXES   = 3;
  localparam int EDGE_W = 34;

  typedef logic signed [EDGE_W-1:0] edge_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               wr_en;
    logic               clr_en;
    logic               issue;
    logic [OWNER_W-1:0] owner;
    logic               last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic adv;
    logic busy;
  } status_t;

  // Lower edge of a box on one axis: center minus half extent.
  function automatic edge_t edge_lo(input logic [31:0] c, input logic [30:0] h);
    edge_t cw;
    edge_t hw;
    cw = $signed({{2{c[31]}}, c});
    hw = $signed({3'b000, h});
    return cw - hw;
  endfunction

  // Upper edge of a box on one axis: center plus half extent.
  function automatic edge_t edge_hi(input logic [31:0] c, input logic [30:0] h);
    edge_t cw;
    edge_t hw;
    cw = $signed({{2{c[31]}}, c});
    hw = $signed({3'b000, h});
    return cw + hw;
  endfunction

endpackage

// File: rtl/core/bto_ctrl.sv
// Controller: request decode and the owner sequencer of a detection pass.
module bto_ctrl #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         req_type,
  output logic               in_ready,
  output bto_pkg::cmd_t      cmd,
  input  bto_pkg::status_t   st
);
  import bto_pkg::*;

  localparam int IDX_W = $clog2(NUM_ENTRIES);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] count;
  logic             accept;
  logic             last_owner;

  // A new word is taken only when idle and no owner is still in flight.
  assign in_ready   = (state == IDLE) && !st.busy;
  assign accept     = in_valid && in_ready;
  assign last_owner = (count == IDX_W'(NUM_ENTRIES - 1));

  // Commands to the datapath.
  always_comb begin
    cmd        = '0;
    cmd.wr_en  = accept && (req_type == REQ_WRITE);
    cmd.clr_en = accept && (req_type == REQ_CLEAR);
    cmd.issue  = (state == RUN) && st.adv;
    cmd.owner  = OWNER_W'(count);
    cmd.last   = last_owner;
  end

  // State and owner counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept && (req_type == REQ_DETECT)) begin
            state <= RUN;
            count <= '0;
          end
        end
        RUN: begin
          if (st.adv) begin
            if (last_owner) begin
              state <= IDLE;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A pass always starts at owner zero.
  a_pass_start: assert property (@(posedge clk) disable iff (rst)
    $rose(state == RUN) |-> count == '0)
    else $error("pass did not start at owner zero");

  // The final owner of a pass is followed by no further issue.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.issue && cmd.last |=> !cmd.issue)
    else $error("owner issued after the final one of a pass");

  // No request is taken while the datapath still holds an owner.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en || cmd.clr_en) |-> !st.busy)
    else $error("table update while an owner is in flight");

endmodule

// File: rtl/core/bto_datapath.sv
// Datapath: box table, owner stage, parallel overlap compare and output register.
module bto_datapath #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bto_pkg::cmd_t                cmd,
  output bto_pkg::status_t             st,
  input  logic [3:0]                   box_index,
  input  logic [31:0]                  center_x,
  input  logic [31:0]                  center_y,
  input  logic [31:0]                  center_z,
  input  logic [30:0]                  half_x,
  input  logic [30:0]                  half_y,
  input  logic [30:0]                  half_z,
  input  logic                         active,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bto_pkg::OWNER_W-1:0]  owner_index,
  output logic [bto_pkg::RESULT_LIMIT-1:0] overlap_mask,
  output logic                         pass_last
);
  import bto_pkg::*;

  localparam int IDX_W = $clog2(NUM_ENTRIES);

  // Table: each entry keeps its widened lower and upper edges per axis.
  edge_t lo_store [NUM_ENTRIES][AXES];
  edge_t hi_store [NUM_ENTRIES][AXES];
  logic [NUM_ENTRIES-1:0] present_marks;
  logic [NUM_ENTRIES-1:0] active_marks;
  logic [NUM_ENTRIES-1:0] live;

  // Owner stage.
  logic             s1_valid;
  logic [IDX_W-1:0] s1_owner;
  logic             s1_last;
  logic             s1_live;
  edge_t            s1_lo [AXES];
  edge_t            s1_hi [AXES];

  logic             adv;
  logic             idx_ok;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  edge_t            in_lo [AXES];
  edge_t            in_hi [AXES];
  logic [RESULT_LIMIT-1:0] mask;

  assign adv     = !out_valid || out_ready;
  assign st.adv  = adv;
  assign st.busy = s1_valid;
  assign live    = present_marks & active_marks;

  // Entries beyond the table are not written.
  assign idx_ok = ({1'b0, box_index} < 5'(NUM_ENTRIES));
  assign wr_idx = box_index[IDX_W-1:0];
  assign rd_idx = cmd.owner[IDX_W-1:0];

  // Edges of the incoming box.
  assign in_lo[0] = edge_lo(center_x, half_x);
  assign in_hi[0] = edge_hi(center_x, half_x);
  assign in_lo[1] = edge_lo(center_y, half_y);
  assign in_hi[1] = edge_hi(center_y, half_y);
  assign in_lo[2] = edge_lo(center_z, half_z);
  assign in_hi[2] = edge_hi(center_z, half_z);

  // Edge store write.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && idx_ok) begin
      for (int a = 0; a < AXES; a++) begin
        lo_store[wr_idx][a] <= in_lo[a];
        hi_store[wr_idx][a] <= in_hi[a];
      end
    end
  end

  // Present and active marks.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_en) begin
      present_marks <= '0;
      active_marks  <= '0;
    end else if (cmd.wr_en && idx_ok) begin
      present_marks[wr_idx] <= 1'b1;
      active_marks[wr_idx]  <= active;
    end
  end

  // Owner stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cmd.issue;
    end
  end

  // Owner stage payload: the owner's edges and liveness.
  always_ff @(posedge clk) begin
    if (adv && cmd.issue) begin
      s1_owner <= rd_idx;
      s1_last  <= cmd.last;
      s1_live  <= live[rd_idx];
      for (int a = 0; a < AXES; a++) begin
        s1_lo[a] <= lo_store[rd_idx][a];
        s1_hi[a] <= hi_store[rd_idx][a];
      end
    end
  end

  // One comparator set per table entry; strict overlap on all three axes.
  for (genvar k = 0; k < RESULT_LIMIT; k++) begin : g_cmp
    if (k < NUM_ENTRIES) begin : g_on
      logic [AXES-1:0] axis_hit;
      for (genvar a = 0; a < AXES; a++) begin : g_axis
        assign axis_hit[a] = (s1_hi[a] > lo_store[k][a]) && (s1_lo[a] < hi_store[k][a]);
      end
      assign mask[k] = s1_live && live[k] && (s1_owner != IDX_W'(k)) && (&axis_hit);
    end else begin : g_off
      assign mask[k] = 1'b0;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      owner_index  <= OWNER_W'(s1_owner);
      overlap_mask <= mask;
      pass_last    <= s1_last;
    end
  end

  // A box never appears in its own overlap list.
  a_no_self: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> overlap_mask[owner_index] == 1'b0)
    else $error("owner bit set in its own mask");

  // The pass end mark sits on the highest table entry.
  a_last_owner: assert property (@(posedge clk) disable iff (rst)
    out_valid && pass_last |-> owner_index == OWNER_W'(NUM_ENTRIES - 1))
    else $error("pass end mark on the wrong owner");

  // The table never changes under an owner that is still being compared.
  a_table_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en || cmd.clr_en) |-> !s1_valid)
    else $error("table written during compare");

endmodule

// File: rtl/core/box_table_pairwise_overlap.sv
// Top level of the box table pairwise overlap detector.
//
//   channel   direction  handshake            word
//   request   in         in_valid / in_ready  req_type, box_index, center_*, half_*, active
//   result    out        out_valid/out_ready  owner_index, overlap_mask, pass_last
//
// A detect word yields one result word per table entry, one owner a cycle unless results
// stall, compared against every entry at once by a bank of parallel edge comparators.
// New request words wait until the last owner of a pass has been compared.
// Result stalls hold the owner sequencer; no word is dropped.
// Reset clears all present and active marks; box edges need no reset.
module box_table_pairwise_overlap #(
  parameter int MAX_BOXES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [3:0]  box_index,
  input  logic [31:0] center_x,
  input  logic [31:0] center_y,
  input  logic [31:0] center_z,
  input  logic [30:0] half_x,
  input  logic [30:0] half_y,
  input  logic [30:0] half_z,
  input  logic        active,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  owner_index,
  output logic [15:0] overlap_mask,
  output logic        pass_last
);
  import bto_pkg::*;

  // Only the first sixteen entries are addressable and reported.
  localparam int NUM_ENTRIES = (MAX_BOXES < RESULT_LIMIT) ? MAX_BOXES : RESULT_LIMIT;

  cmd_t    cmd;
  status_t st;

  // Request decode and owner sequencing.
  bto_ctrl #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  // Box table and overlap compare.
  bto_datapath #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .box_index    (box_index),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_z     (center_z),
    .half_x       (half_x),
    .half_y       (half_y),
    .half_z       (half_z),
    .active       (active),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .owner_index  (owner_index),
    .overlap_mask (overlap_mask),
    .pass_last    (pass_last)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the box table pairwise overlap detector.
`timescale 1ns / 1ps

module tb_top;
  import bto_pkg::*;

  localparam int BOXES          = 16;
  localparam int MAX_WAIT       = 18;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_ITEMS   = 400;
  localparam int DRILL_ROWS     = 23;

  // The one request code the block must ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Handy Q16.16 values.
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_HALF = 32'h0000_8000;
  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_ALL  = 32'hFFFF_FFFF;
  localparam logic [30:0] H_ONE  = 31'h0001_0000;
  localparam logic [30:0] H_MAX  = 31'h7FFF_FFFF;

  // Masks of owners 0 to 3, owner 0 leftmost; owners 4 to 15 must be zero.
  localparam logic [0:3][15:0] ZERO_PIN = '0;

  typedef enum int {MODE_CLUSTER, MODE_WIDE, MODE_EDGE, MODE_ABUT} scene_mode_t;

  // One request word; axis 0 is x, 1 is y, 2 is z.
  typedef struct packed {
    logic [1:0]       req;
    logic [3:0]       idx;
    logic [2:0][31:0] cen;
    logic [2:0][30:0] hlf;
    logic             act;
  } box_req_t;

  // One result word.
  typedef struct packed {
    logic [3:0]  owner;
    logic [15:0] mask;
    logic        last;
  } overlap_word_t;

  typedef struct {
    box_req_t         w;
    bit               pinned;
    logic [0:3][15:0] pin;
  } drill_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [3:0]  box_index;
  logic [31:0] center_x;
  logic [31:0] center_y;
  logic [31:0] center_z;
  logic [30:0] half_x;
  logic [30:0] half_y;
  logic [30:0] half_z;
  logic        active;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  owner_index;
  logic [15:0] overlap_mask;
  logic        pass_last;

  // Shadow copy of the box table.
  logic [31:0] tab_cen [BOXES][3];
  logic [30:0] tab_hlf [BOXES][3];
  bit          tab_act [BOXES];
  bit          tab_present [BOXES];

  overlap_word_t pending_masks [$];
  drill_row_t    drill_rows [DRILL_ROWS];

  // Last written box, used to build abutting neighbors.
  logic [31:0] chain_cen [3];
  logic [30:0] chain_hlf [3];

  int err_count = 0;
  int sent_items;
  int idle_cycles = 0;
  int rx_hold;
  bit calm;

  box_table_pairwise_overlap #(.MAX_BOXES(BOXES)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wait drawn before each word; calm stretches run with no idling at all.
  function automatic int draw_wait();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, MAX_WAIT);
    return $urandom_range(0, 2);
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Strict overlap on one axis, with the edges formed in 64 bits.
  function automatic bit axis_hit(logic [31:0] ca, logic [30:0] ha,
                                  logic [31:0] cb, logic [30:0] hb);
    longint a;
    longint b;
    longint da;
    longint db;
    a  = longint'($signed(ca));
    b  = longint'($signed(cb));
    da = longint'({1'b0, ha});
    db = longint'({1'b0, hb});
    return (a + da > b - db) && (a - da < b + db);
  endfunction

  function automatic bit box_live(int i);
    return tab_present[i] && tab_act[i];
  endfunction

  // Update the shadow table, or queue the masks that a detection pass yields.
  function automatic void apply_request(box_req_t w);
    logic [15:0] mask;
    bit          hit;
    case (w.req)
      REQ_WRITE: begin
        for (int a = 0; a < 3; a++) begin
          tab_cen[w.idx][a] = w.cen[a];
          tab_hlf[w.idx][a] = w.hlf[a];
        end
        tab_act[w.idx]     = w.act;
        tab_present[w.idx] = 1'b1;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < BOXES; i++) begin
          tab_act[i]     = 1'b0;
          tab_present[i] = 1'b0;
        end
      end
      REQ_DETECT: begin
        for (int i = 0; i < BOXES; i++) begin
          mask = '0;
          if (box_live(i)) begin
            for (int k = 0; k < BOXES; k++) begin
              hit = (k != i) && box_live(k);
              for (int a = 0; a < 3; a++)
                hit = hit && axis_hit(tab_cen[i][a], tab_hlf[i][a],
                                      tab_cen[k][a], tab_hlf[k][a]);
              mask[k] = hit;
            end
          end
          pending_masks.push_back('{owner: 4'(i), mask: mask, last: (i == BOXES - 1)});
        end
      end
      default: begin
        // Unused code: no state change and no words.
      end
    endcase
  endfunction

  function automatic drill_row_t drill(logic [1:0] req, logic [3:0] idx,
                                       logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                       logic [30:0] h, logic act, bit pinned,
                                       logic [0:3][15:0] pin);
    drill_row_t r;
    r.w.req = req;
    r.w.idx = idx;
    r.w.cen = {cz, cy, cx};
    r.w.hlf = {h, h, h};
    r.w.act = act;
    r.pinned = pinned;
    r.pin = pin;
    return r;
  endfunction

  // Random payload under a given request code.
  function automatic box_req_t noise_word(logic [1:0] req);
    box_req_t w;
    w.req = req;
    w.idx = 4'($urandom());
    for (int a = 0; a < 3; a++) begin
      w.cen[a] = $urandom();
      w.hlf[a] = 31'($urandom());
    end
    w.act = 1'($urandom());
    return w;
  endfunction

  // A box write shaped by the scene: clustered, wide, extreme or abutting.
  function automatic box_req_t random_box(scene_mode_t mode, logic [31:0] base);
    box_req_t w;
    w.req = REQ_WRITE;
    w.idx = 4'($urandom_range(0, BOXES - 1));
    w.act = ($urandom_range(0, 7) != 0);
    for (int a = 0; a < 3; a++) begin
      case (mode)
        MODE_WIDE: begin
          w.cen[a] = $urandom();
          w.hlf[a] = 31'($urandom());
        end
        MODE_EDGE: begin
          case ($urandom_range(0, 3))
            0: w.cen[a] = Q_MAX;
            1: w.cen[a] = Q_MIN;
            2: w.cen[a] = '0;
            default: w.cen[a] = Q_ALL;
          endcase
          case ($urandom_range(0, 3))
            0: w.hlf[a] = '0;
            1: w.hlf[a] = 31'd1;
            2: w.hlf[a] = H_ONE;
            default: w.hlf[a] = H_MAX;
          endcase
        end
        MODE_ABUT: begin
          // Touch the previous box on x exactly; share its y and z centers.
          w.hlf[a] = 31'($urandom_range(0, 32'h3_0000));
          if (a == 0) w.cen[a] = chain_cen[0] + {1'b0, chain_hlf[0]} + {1'b0, w.hlf[0]};
          else w.cen[a] = chain_cen[a];
        end
        default: begin
          w.cen[a] = base + 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
          w.hlf[a] = 31'($urandom_range(0, 32'h3_0000));
        end
      endcase
    end
    for (int a = 0; a < 3; a++) begin
      chain_cen[a] = w.cen[a];
      chain_hlf[a] = w.hlf[a];
    end
    return w;
  endfunction

  // Present one request word and hold it until the block takes it.
  task automatic drive_word(box_req_t w);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= w.req;
    box_index <= w.idx;
    center_x  <= w.cen[0];
    center_y  <= w.cen[1];
    center_z  <= w.cen[2];
    half_x    <= w.hlf[0];
    half_y    <= w.hlf[1];
    half_z    <= w.hlf[2];
    active    <= w.act;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.req != REQ_UNUSED) sent_items++;
  endtask

  task automatic issue(box_req_t w);
    drive_word(w);
    apply_request(w);
  endtask

  // Stop sending until every queued mask has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_masks.size() != 0) @(posedge clk);
  endtask

  // One scene: usually a clear, a batch of writes, then one or two passes.
  task automatic run_scene();
    scene_mode_t mode;
    scene_mode_t pick;
    logic [31:0] base;
    int          n;
    case ($urandom_range(0, 9))
      6: mode = MODE_WIDE;
      7: mode = MODE_EDGE;
      default: mode = MODE_CLUSTER;
    endcase
    base = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
    calm = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 2) != 0) issue(noise_word(REQ_CLEAR));
    n = $urandom_range(1, 12);
    repeat (n) begin
      if ($urandom_range(0, 11) == 0) issue(noise_word(REQ_UNUSED));
      pick = mode;
      if (mode == MODE_CLUSTER && $urandom_range(0, 3) == 0) pick = MODE_ABUT;
      issue(random_box(pick, base));
    end
    // Now and then a clear breaks the sequence before the pass.
    if ($urandom_range(0, 5) == 0) issue(noise_word(REQ_CLEAR));
    issue(noise_word(REQ_DETECT));
    if ($urandom_range(0, 4) == 0) issue(noise_word(REQ_DETECT));
  endtask

  // Result side: random stalls and a field by field compare.
  always @(posedge clk) begin
    overlap_word_t exp_w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_masks.size() == 0) begin
          report_mismatch($sformatf("unexpected word owner %0d mask %h last %b",
                                    owner_index, overlap_mask, pass_last));
        end else begin
          exp_w = pending_masks.pop_front();
          if (owner_index !== exp_w.owner)
            report_mismatch($sformatf("owner_index got %0d expected %0d",
                                      owner_index, exp_w.owner));
          if (overlap_mask !== exp_w.mask)
            report_mismatch($sformatf("owner %0d overlap_mask got %h expected %h",
                                      exp_w.owner, overlap_mask, exp_w.mask));
          if (pass_last !== exp_w.last)
            report_mismatch($sformatf("owner %0d pass_last got %b expected %b",
                                      exp_w.owner, pass_last, exp_w.last));
        end
        rx_hold = draw_wait();
      end else if (out_valid && rx_hold > 0) begin
        rx_hold--;
      end
      out_ready <= (rx_hold == 0);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, random scenes, drain.
  initial begin
    int target;
    bit paused;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    req_type  <= REQ_WRITE;
    box_index <= '0;
    center_x  <= '0;
    center_y  <= '0;
    center_z  <= '0;
    half_x    <= '0;
    half_y    <= '0;
    half_z    <= '0;
    active    <= 1'b0;
    sent_items  = 0;
    calm        = 1'b0;
    paused      = 1'b0;
    for (int i = 0; i < BOXES; i++) begin
      tab_act[i]     = 1'b0;
      tab_present[i] = 1'b0;
    end
    for (int a = 0; a < 3; a++) begin
      chain_cen[a] = '0;
      chain_hlf[a] = H_ONE;
    end

    // Empty table after reset, and the unused code leaves it empty.
    drill_rows[0]  = drill(REQ_DETECT, 4'd0, '0, '0, '0, '0, 1'b0, 1'b1, ZERO_PIN);
    drill_rows[1]  = drill(REQ_UNUSED, 4'hF, Q_ALL, Q_ALL, Q_ALL, H_MAX, 1'b1, 1'b0, ZERO_PIN);
    drill_rows[2]  = drill(REQ_DETECT, 4'd0, '0, '0, '0, '0, 1'b0, 1'b1, ZERO_PIN);
    // Two overlapping unit boxes and a point box far away.
    drill_rows[3]  = drill(REQ_WRITE, 4'd0, '0, '0, '0, H_ONE, 1'b1, 1'b0, ZERO_PIN);
    drill_rows[4]  = drill(REQ_WRITE, 4'd1, Q_HALF, Q_HALF, Q_HALF, H_ONE, 1'b1, 1'b0, ZERO_PIN);
    drill_rows[5]  = drill(REQ_WRITE, 4'd2, Q_MAX, Q_MAX, Q_MAX, '0, 1'b1, 1'b0, ZERO_PIN);
    drill_rows[6]  = drill(REQ_DETECT, 4'd0, '0, '0, '0, '0, 1'b0, 1'b1,
                           {16'h0002, 16'h0001, 16'h0000, 16'h0000});
    // A present but inactive box on top of box 0 changes nothing.
    drill_rows[7]  = drill(REQ_WRITE, 4'd3, '0, '0, '0, H_ONE, 1'b0, 1'b0, ZERO_PIN);
    drill_rows[8]  = drill(REQ_DETECT, 4'd0, '0, '0, '0, '0, 1'b0, 1'b1,
                           {16'h0002, 16'h0001, 16'h0000, 16'h0000});
    // Box 2 touches box 0 exactly on x, which is not an overlap.
    drill_rows[9]  = drill(REQ_WRITE, 4'd2, Q_ONE << 1, '0, '0, H_ONE, 1'b1, 1'b0, ZERO_PIN);
    drill_rows[10] = drill(REQ_DETECT, 4'd0, '0, '0, '0, '0, 1'b0, 1'b1,
                           {16'h0002, 16'h0005, 16'h0002, 16'h0000});
    // Extreme centers and half extents, then the top entry and a point box.
    drill_rows[11] = drill(REQ_WRITE, 4'd4, Q_MAX, Q_MAX, Q_MAX, H_MAX, 1'b1, 1'b0, ZERO_PIN);
    drill_rows[12] = drill(REQ_WRITE, 4'd5, Q_MIN, Q_MIN, Q_MIN, H_MAX, 1'b1, 1'b0, ZERO_PIN);
    drill_rows[13] = drill(REQ_DETECT, 4'd0, '0, '0, '0, '0, 1'b0, 1'b0, ZERO_PIN);
    drill_rows[14] = drill(REQ_WRITE, 4'hF, Q_MIN, Q_MAX, '0, H_MAX, 1'b1, 1'b0, ZERO_PIN);
    drill_rows[15] = drill(REQ_WRITE, 4'd3, '0, '0, '0, '0, 1'b1, 1'b0, ZERO_PIN);
    drill_rows[16] = drill(REQ_DETECT, 4'hF, Q_ALL, Q_ALL, Q_ALL, H_MAX, 1'b1, 1'b0, ZERO_PIN);
    // Clear empties the table; a lone live box has nothing to hit.
    drill_rows[17] = drill(REQ_CLEAR, 4'hF, Q_ALL, Q_ALL, Q_ALL, H_MAX, 1'b1, 1'b0, ZERO_PIN);
    drill_rows[18] = drill(REQ_DETECT, 4'd0, '0, '0, '0, '0, 1'b0, 1'b1, ZERO_PIN);
    drill_rows[19] = drill(REQ_WRITE, 4'd1, '0, '0, '0, H_ONE, 1'b0, 1'b0, ZERO_PIN);
    drill_rows[20] = drill(REQ_WRITE, 4'd0, '0, '0, '0, H_ONE, 1'b1, 1'b0, ZERO_PIN);
    drill_rows[21] = drill(REQ_DETECT, 4'd0, '0, '0, '0, '0, 1'b0, 1'b1, ZERO_PIN);
    drill_rows[22] = drill(REQ_CLEAR, 4'd0, '0, '0, '0, '0, 1'b0, 1'b0, ZERO_PIN);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; pinned passes carry their masks in the table.
    foreach (drill_rows[r]) begin
      drive_word(drill_rows[r].w);
      if (drill_rows[r].pinned) begin
        for (int i = 0; i < BOXES; i++)
          pending_masks.push_back('{owner: 4'(i),
                                    mask: (i < 4) ? drill_rows[r].pin[i] : 16'h0000,
                                    last: (i == BOXES - 1)});
      end else begin
        apply_request(drill_rows[r].w);
      end
    end
    hold_until_drained();

    // Random scenes, with one full drain halfway through.
    target = sent_items + RANDOM_ITEMS;
    while (sent_items < target) begin
      if (!paused && sent_items >= target - RANDOM_ITEMS / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      run_scene();
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bto_pkg.sv
rtl/core/bto_ctrl.sv
rtl/core/bto_datapath.sv
rtl/core/box_table_pairwise_overlap.sv
verif/tb_top.sv
